>>> rtl/core/tpt_pkg.sv
// Package for the touch pen tracker: item types, register indexes, event and
// phase codes, and the default calibration. Depends on nothing.
`default_nettype none
package tpt_pkg;

    // Geometry and filter defaults
    localparam int TPT_SCREEN_WIDTH  = 240;
    localparam int TPT_SCREEN_HEIGHT = 320;
    localparam int TPT_HISTORY_DEPTH = 4;
    localparam int TPT_FRACTION_BITS = 13;

    // Jump thresholds, raw sample steps
    localparam logic [9:0] THR_FAST   = 10'd200;
    localparam logic [9:0] THR_NORMAL = 10'd320;
    localparam logic [1:0] REJECT_MAX = 2'd3;

    // Register reset values
    localparam logic signed [11:0] OFFSET_X_RST = -12'sd96;
    localparam logic signed [11:0] OFFSET_Y_RST = -12'sd116;
    localparam logic signed [15:0] GAIN_X_RST   = 16'sd2155;
    localparam logic signed [15:0] GAIN_Y_RST   = 16'sd2899;

    // Register indexes
    localparam logic [2:0] REG_FAST_MODE = 3'd0;
    localparam logic [2:0] REG_OFFSET_X  = 3'd1;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd2;
    localparam logic [2:0] REG_GAIN_X    = 3'd3;
    localparam logic [2:0] REG_GAIN_Y    = 3'd4;

    // Pen phase codes
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_DOWN = 2'd1;
    localparam logic [1:0] PH_MOVE = 2'd2;
    localparam logic [1:0] PH_STAY = 2'd3;

    // Event codes
    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_MOVE = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    // One poll tick
    typedef struct packed {
        logic        pressed;
        logic [11:0] x_sample;
        logic [11:0] y_sample;
        logic [31:0] time_ms;
    } tick_item_t;

    // One pen event
    typedef struct packed {
        logic [1:0]         event_kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        event_time;
    } report_item_t;

endpackage
`default_nettype wire

>>> rtl/core/touch_pen_tracker_core.sv
// Touch pen tracker top level: jump filter, calibration mapping, event output.
// Depends on tpt_pkg.
//
// A tick passes the tick register and then the report register before its report is valid.
// Throughput: one tick per cycle; the history and phase update is made as each tick is processed.
// A tick stalls only while a report waits in the output register and is not taken.
// Reset (rst_n low, async): phase none, position and time zero, history empty,
// registers at their calibration defaults. History samples are not cleared.
`default_nettype none
module touch_pen_tracker_core #(
    parameter int SCREEN_WIDTH  = tpt_pkg::TPT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tpt_pkg::TPT_SCREEN_HEIGHT,
    parameter int HISTORY_DEPTH = tpt_pkg::TPT_HISTORY_DEPTH,
    parameter int FRACTION_BITS = tpt_pkg::TPT_FRACTION_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tick_valid,
    output logic                       tick_ready,
    input  wire tpt_pkg::tick_item_t   tick,
    output logic                       report_valid,
    input  wire logic                  report_ready,
    output tpt_pkg::report_item_t      report,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [15:0]           cfg_data
);
    import tpt_pkg::*;

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    // Configuration registers
    logic               fast_mode_reg;
    logic signed [11:0] offset_x_reg, offset_y_reg;
    logic signed [15:0] gain_x_reg, gain_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_mode_reg <= 1'b0;
            offset_x_reg  <= OFFSET_X_RST;
            offset_y_reg  <= OFFSET_Y_RST;
            gain_x_reg    <= GAIN_X_RST;
            gain_y_reg    <= GAIN_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FAST_MODE: fast_mode_reg <= cfg_data[0];
                REG_OFFSET_X:  offset_x_reg  <= signed'(cfg_data[11:0]);
                REG_OFFSET_Y:  offset_y_reg  <= signed'(cfg_data[11:0]);
                REG_GAIN_X:    gain_x_reg    <= signed'(cfg_data);
                REG_GAIN_Y:    gain_y_reg    <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // Tick register; offsets are added on capture (sum spans -2048..6142)
    logic               tick_valid_reg;
    tick_item_t         tick_reg;
    logic signed [13:0] xo_reg, yo_reg;
    logic               fire;
    logic               emit;
    report_item_t       report_next;

    assign tick_ready = !tick_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick_ready)
        begin
            tick_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            tick_reg <= tick;
            xo_reg   <= signed'({2'b0, tick.x_sample}) + 14'(offset_x_reg);
            yo_reg   <= signed'({2'b0, tick.y_sample}) + 14'(offset_y_reg);
        end
    end

    // Tracker state
    logic [1:0]       phase_reg, phase_next;
    logic [15:0]      cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [31:0]      last_time_reg, last_time_next;
    logic [CNT_W-1:0] hist_count_reg, hist_count_next;
    logic [PTR_W-1:0] hist_wptr_reg, hist_wptr_next;
    logic [1:0]       reject_run_reg, reject_run_next;
    logic [11:0]      hist_x_reg [HISTORY_DEPTH];
    logic [11:0]      hist_y_reg [HISTORY_DEPTH];

    // A tick is processed once the report slot is free or being emptied
    assign fire = tick_valid_reg && (!report_valid || report_ready);

    // Calibration mapping: floor((s + off) * gain >> F), mirrored
    logic signed [29:0] prod_x, prod_y;
    logic signed [31:0] prod_x_w, prod_y_w, pos_x_w, pos_y_w;
    logic [15:0]        nx, ny;

    assign prod_x   = xo_reg * gain_x_reg;
    assign prod_y   = yo_reg * gain_y_reg;
    assign prod_x_w = 32'(prod_x);
    assign prod_y_w = 32'(prod_y);
    assign pos_x_w  = 32'(SCREEN_WIDTH) - (prod_x_w >>> FRACTION_BITS);
    assign pos_y_w  = 32'(SCREEN_HEIGHT) - (prod_y_w >>> FRACTION_BITS);
    assign nx       = pos_x_w[15:0];
    assign ny       = pos_y_w[15:0];

    // Jump filter against the live history entries
    logic [9:0]              thr;
    logic                    phase_none;
    logic [CNT_W-1:0]        eff_count;
    logic [PTR_W-1:0]        eff_wptr;
    logic [HISTORY_DEPTH-1:0] match_vec;
    logic                    pass;
    logic [1:0]              reject_inc;
    logic signed [13:0]      dx, dy, thr_s;

    assign thr        = fast_mode_reg ? THR_FAST : THR_NORMAL;
    assign thr_s      = signed'({4'b0, thr});
    assign phase_none = (phase_reg == PH_NONE);
    assign eff_count  = phase_none ? '0 : hist_count_reg;
    assign eff_wptr   = phase_none ? '0 : hist_wptr_reg;

    always_comb
    begin
        match_vec = '0;
        dx = '0;
        dy = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            dx = signed'({2'b0, tick_reg.x_sample}) - signed'({2'b0, hist_x_reg[i]});
            dy = signed'({2'b0, tick_reg.y_sample}) - signed'({2'b0, hist_y_reg[i]});
            match_vec[i] = (CNT_W'(i) < eff_count) && (dx < thr_s) && (dx > -thr_s)
                           && (dy < thr_s) && (dy > -thr_s);
        end
    end

    assign pass       = (eff_count == '0) || (|match_vec);
    assign reject_inc = (reject_run_reg == REJECT_MAX) ? REJECT_MAX : reject_run_reg + 2'd1;

    // Next state and report
    always_comb
    begin
        phase_next      = phase_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        last_time_next  = last_time_reg;
        hist_count_next = hist_count_reg;
        hist_wptr_next  = hist_wptr_reg;
        reject_run_next = reject_run_reg;
        emit            = 1'b0;
        report_next.event_kind = EV_UP;
        if (!tick_reg.pressed)
        begin
            // release: report the last position once
            if (!phase_none)
            begin
                phase_next = PH_NONE;
                emit       = 1'b1;
            end
        end
        else if (pass)
        begin
            hist_wptr_next  = (eff_wptr == PTR_LAST) ? '0 : eff_wptr + PTR_W'(1);
            hist_count_next = (eff_count == CNT_FULL) ? CNT_FULL : eff_count + CNT_W'(1);
            reject_run_next = '0;
            last_time_next  = tick_reg.time_ms;
            if (phase_none)
            begin
                phase_next = PH_DOWN;
                cur_x_next = nx;
                cur_y_next = ny;
                emit       = 1'b1;
                report_next.event_kind = EV_DOWN;
            end
            else if (nx == cur_x_reg && ny == cur_y_reg)
            begin
                phase_next = PH_STAY;
            end
            else
            begin
                phase_next = PH_MOVE;
                cur_x_next = nx;
                cur_y_next = ny;
                emit       = 1'b1;
                report_next.event_kind = EV_MOVE;
            end
        end
        else
        begin
            // rejected jump; a full run empties the history
            reject_run_next = reject_inc;
            if (reject_inc == REJECT_MAX)
            begin
                hist_count_next = '0;
                hist_wptr_next  = '0;
            end
        end
        report_next.pos_x      = signed'(cur_x_next);
        report_next.pos_y      = signed'(cur_y_next);
        report_next.event_time = last_time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_NONE;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            last_time_reg  <= '0;
            hist_count_reg <= '0;
            hist_wptr_reg  <= '0;
            reject_run_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            last_time_reg  <= last_time_next;
            hist_count_reg <= hist_count_next;
            hist_wptr_reg  <= hist_wptr_next;
            reject_run_reg <= reject_run_next;
        end
    end

    // History samples, written on each accepted sample
    always_ff @(posedge clk)
    begin
        if (fire && tick_reg.pressed && pass)
        begin
            hist_x_reg[eff_wptr] <= tick_reg.x_sample;
            hist_y_reg[eff_wptr] <= tick_reg.y_sample;
        end
    end

    // Report register
    logic         report_valid_reg;
    report_item_t report_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            report_valid_reg <= emit;
        end
        else if (report_ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            report_reg <= report_next;
        end
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hist_count_reg <= CNT_FULL)
        else $error("history count beyond depth");

    a_wptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hist_wptr_reg <= PTR_LAST)
        else $error("history write pointer beyond depth");

    a_run_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (reject_run_reg == REJECT_MAX) |-> (hist_count_reg == '0))
        else $error("full reject run left history entries");

    a_up_ends_touch: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit && report_next.event_kind == EV_UP) |=> (phase_reg == PH_NONE))
        else $error("pen up report without return to no contact");

    a_down_from_none: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit && report_next.event_kind == EV_DOWN) |-> phase_none)
        else $error("pen down report during contact");

endmodule
`default_nettype wire

>>> tb/sv/touch_pen_tracker_core_tb.sv
// Self-checking testbench for touch_pen_tracker_core: directed ticks from a table, then
// random pen gestures under several calibrations, each report checked against a predictor or a given report.
// Depends on tpt_pkg and the touch_pen_tracker_core RTL.
`default_nettype none
module touch_pen_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpt_pkg::*;

    localparam int IDLE_LIMIT       = 5000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 400;
    localparam int PHASES           = 12;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int SAMPLE_MAX       = 4095;
    localparam logic [2:0] STRAY_INDEX_MAX = 3'd7;

    typedef enum {ROW_TICK, ROW_REG} row_kind_t;
    // How a table row is checked: by the predictor, as silent, or by a typed-in report
    typedef enum {CHK_MODEL, CHK_QUIET, CHK_GIVEN} row_check_t;
    // Kinds of pen motion between two samples of a gesture
    typedef enum {HOP_STAY, HOP_SMALL, HOP_WIDE, HOP_EDGE, HOP_JUMP} hop_t;

    typedef struct {
        row_kind_t    kind;
        tick_item_t   item;
        row_check_t   chk;
        report_item_t given;
        logic [2:0]   index;
        logic [15:0]  data;
    } script_row_t;

    localparam report_item_t NO_REPORT = '0;

    logic         clk;
    logic         rst_n;
    logic         tick_valid;
    logic         tick_ready;
    tick_item_t   tick;
    logic         report_valid;
    logic         report_ready;
    report_item_t report;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;

    touch_pen_tracker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Tracker state as predicted
    logic                trk_fast;
    logic signed [11:0]  trk_off_x;
    logic signed [11:0]  trk_off_y;
    logic signed [15:0]  trk_gain_x;
    logic signed [15:0]  trk_gain_y;
    logic [1:0]          trk_phase;
    logic [15:0]         trk_cur_x;
    logic [15:0]         trk_cur_y;
    logic [31:0]         trk_last_t;
    logic [11:0]         trk_hist_x [TPT_HISTORY_DEPTH];
    logic [11:0]         trk_hist_y [TPT_HISTORY_DEPTH];
    int                  trk_hist_cnt;
    int                  trk_hist_wp;
    int                  trk_rejects;

    report_item_t pen_events_due [$];
    script_row_t  script [$];
    int           mismatches;
    int           items_counted;
    int           idle_cycles;
    bit           hold_req;
    logic [31:0]  tnow;
    report_item_t want_rep;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Raw sample to mirrored screen coordinate, floor shift, wrapped to 16 bits
    function automatic logic [15:0] screen_coord(logic [11:0] raw, logic signed [11:0] off,
                                                 logic signed [15:0] gain, int size);
        longint prod;
        longint pos;
        prod = (longint'(raw) + longint'(off)) * longint'(gain);
        pos  = longint'(size) - (prod >>> TPT_FRACTION_BITS);
        return pos[15:0];
    endfunction

    // Jump filter against the recent accepted samples; updates history and reject run
    function automatic bit jump_filter(logic [11:0] xs, logic [11:0] ys);
        int thr;
        int dx;
        int dy;
        bit ok;
        thr = trk_fast ? int'(THR_FAST) : int'(THR_NORMAL);
        ok  = 1'b1;
        if (trk_phase == PH_NONE)
        begin
            trk_hist_cnt = 0;
            trk_hist_wp  = 0;
        end
        else if (trk_hist_cnt >= 1)
        begin
            ok = 1'b0;
            for (int i = 0; i < trk_hist_cnt; i++)
            begin
                dx = int'(xs) - int'(trk_hist_x[i]);
                dy = int'(ys) - int'(trk_hist_y[i]);
                if (dx < thr && dx > -thr && dy < thr && dy > -thr)
                    ok = 1'b1;
            end
        end
        if (ok)
        begin
            trk_hist_x[trk_hist_wp] = xs;
            trk_hist_y[trk_hist_wp] = ys;
            trk_hist_wp = (trk_hist_wp + 1) % TPT_HISTORY_DEPTH;
            if (trk_hist_cnt < TPT_HISTORY_DEPTH)
                trk_hist_cnt++;
            trk_rejects = 0;
        end
        else
        begin
            if (trk_rejects < int'(REJECT_MAX))
                trk_rejects++;
            if (trk_rejects >= int'(REJECT_MAX))
            begin
                trk_hist_cnt = 0;
                trk_hist_wp  = 0;
            end
        end
        return ok;
    endfunction

    // One poll tick through the tracker: at most one pen event
    function automatic void track_tick(input tick_item_t t, output bit emits,
                                       output report_item_t rep);
        logic [15:0] nx;
        logic [15:0] ny;
        emits = 1'b0;
        rep   = NO_REPORT;
        if (!t.pressed)
        begin
            if (trk_phase != PH_NONE)
            begin
                trk_phase = PH_NONE;
                emits = 1'b1;
                rep = '{EV_UP, trk_cur_x, trk_cur_y, trk_last_t};
            end
        end
        else if (jump_filter(t.x_sample, t.y_sample))
        begin
            nx = screen_coord(t.x_sample, trk_off_x, trk_gain_x, TPT_SCREEN_WIDTH);
            ny = screen_coord(t.y_sample, trk_off_y, trk_gain_y, TPT_SCREEN_HEIGHT);
            trk_last_t = t.time_ms;
            if (trk_phase == PH_NONE)
            begin
                trk_phase = PH_DOWN;
                trk_cur_x = nx;
                trk_cur_y = ny;
                emits = 1'b1;
                rep = '{EV_DOWN, nx, ny, trk_last_t};
            end
            else if (nx == trk_cur_x && ny == trk_cur_y)
                trk_phase = PH_STAY;
            else
            begin
                trk_phase = PH_MOVE;
                trk_cur_x = nx;
                trk_cur_y = ny;
                emits = 1'b1;
                rep = '{EV_MOVE, nx, ny, trk_last_t};
            end
        end
    endfunction

    // Register write as the block sees it, masked to width
    function automatic void apply_reg(logic [2:0] index, logic [15:0] data);
        case (index)
            REG_FAST_MODE: trk_fast   = data[0];
            REG_OFFSET_X:  trk_off_x  = data[11:0];
            REG_OFFSET_Y:  trk_off_y  = data[11:0];
            REG_GAIN_X:    trk_gain_x = data;
            REG_GAIN_Y:    trk_gain_y = data;
            default: ;
        endcase
    endfunction

    function automatic void add_tick(bit p, int x, int y, logic [31:0] t, row_check_t chk,
                                     report_item_t given);
        script_row_t row;
        row.kind  = ROW_TICK;
        row.item  = '{p, 12'(x), 12'(y), t};
        row.chk   = chk;
        row.given = given;
        row.index = '0;
        row.data  = '0;
        script.push_back(row);
    endfunction

    function automatic void add_reg(logic [2:0] index, logic [15:0] data);
        script_row_t row;
        row.kind  = ROW_REG;
        row.item  = '0;
        row.chk   = CHK_QUIET;
        row.given = NO_REPORT;
        row.index = index;
        row.data  = data;
        script.push_back(row);
    endfunction

    // Sender gap: mostly none or short, a few long
    function automatic int gap_len(bit quick);
        int r;
        if (quick)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Next coordinate of a gesture for one kind of motion
    function automatic int nudge(int v, hop_t hop, int thr);
        int d;
        d = 0;
        case (hop)
            HOP_SMALL: d = int'($urandom_range(0, 30)) - 15;
            HOP_WIDE:  d = int'($urandom_range(0, 2 * thr - 2)) - (thr - 1);
            HOP_EDGE:  d = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(thr - 1, thr));
            HOP_JUMP:  return $urandom_range(0, SAMPLE_MAX);
            default:   d = 0;
        endcase
        v = v + d;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v;
    endfunction

    function automatic hop_t pick_hop();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)
            return HOP_STAY;
        if (r < 12)
            return HOP_SMALL;
        if (r < 16)
            return HOP_WIDE;
        if (r < 18)
            return HOP_EDGE;
        return HOP_JUMP;
    endfunction

    // Offer one tick, wait for its accept, then queue what it should cause
    task automatic send_tick(tick_item_t item, int gap, row_check_t chk, report_item_t given);
        bit           emits;
        report_item_t rep;
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick       <= item;
        tick_valid <= 1'b1;
        do @(posedge clk); while (!tick_ready);
        if (item.pressed || trk_phase != PH_NONE)
            items_counted++;
        track_tick(item, emits, rep);
        case (chk)
            CHK_MODEL: if (emits) pen_events_due.push_back(rep);
            CHK_GIVEN: pen_events_due.push_back(given);
            default: ;
        endcase
    endtask

    // Stop offering and let every pending event and any silent tick clear the block
    task automatic drain();
        tick_valid <= 1'b0;
        while (pen_events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [15:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Calibration per phase: defaults, both extremes, low gain, then random
    task automatic configure_phase(int ph);
        logic              fast;
        logic signed [11:0] ox;
        logic signed [11:0] oy;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        fast = 1'($urandom_range(0, 1));
        ox   = 12'($urandom);
        oy   = 12'($urandom);
        gx   = 16'($urandom);
        gy   = 16'($urandom);
        case (ph)
            0:
            begin
                fast = 1'b0;
                ox = OFFSET_X_RST;
                oy = OFFSET_Y_RST;
                gx = GAIN_X_RST;
                gy = GAIN_Y_RST;
            end
            1:
            begin
                fast = 1'b1;
                ox = 12'sh7FF;
                oy = 12'sh7FF;
                gx = 16'sh7FFF;
                gy = 16'sh7FFF;
            end
            2:
            begin
                fast = 1'b0;
                ox = 12'sh800;
                oy = 12'sh800;
                gx = 16'sh8000;
                gy = 16'sh8000;
            end
            3:
            begin
                gx = 16'(int'($urandom_range(0, 128)) - 64);
                gy = 16'(int'($urandom_range(0, 128)) - 64);
            end
            default: ;
        endcase
        // Unused upper bits carry noise; the block must mask them
        write_reg(REG_FAST_MODE, {15'($urandom), fast});
        write_reg(REG_OFFSET_X, {4'($urandom), ox});
        write_reg(REG_OFFSET_Y, {4'($urandom), oy});
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
        if ($urandom_range(0, 1))
            write_reg(3'($urandom_range(int'(REG_GAIN_Y) + 1, int'(STRAY_INDEX_MAX))),
                      16'($urandom));
    endtask

    // One pen gesture: touch, a walk of samples, lift; sometimes just a noise tick
    task automatic run_gesture(bit busy);
        tick_item_t it;
        hop_t       hop;
        bit         quick;
        int         len;
        int         x;
        int         y;
        int         thr;
        quick = busy || ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            it = '{1'($urandom), 12'($urandom), 12'($urandom), $urandom()};
            send_tick(it, gap_len(quick), CHK_MODEL, NO_REPORT);
            return;
        end
        len = $urandom_range(1, 40);
        x   = $urandom_range(0, SAMPLE_MAX);
        y   = $urandom_range(0, SAMPLE_MAX);
        thr = trk_fast ? int'(THR_FAST) : int'(THR_NORMAL);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0)
            begin
                hop = pick_hop();
                x = nudge(x, hop, thr);
                y = nudge(y, hop, thr);
            end
            if ($urandom_range(0, 49) == 0)
                tnow = $urandom();
            else
                tnow = tnow + $urandom_range(1, 20);
            // An occasional lift in mid gesture
            it = '{($urandom_range(0, 29) != 0), 12'(x), 12'(y), tnow};
            send_tick(it, gap_len(quick), CHK_MODEL, NO_REPORT);
        end
        tnow = tnow + $urandom_range(1, 20);
        it = '{1'b0, 12'($urandom), 12'($urandom), tnow};
        send_tick(it, gap_len(quick), CHK_MODEL, NO_REPORT);
    endtask

    // Receiver: random stalls, with a long hold-off on request
    initial
    begin
        report_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                report_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    report_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
                else
                begin
                    report_ready <= 1'b0;
                    if (r < 88)
                        repeat ($urandom_range(1, 3)) @(posedge clk);
                    else if (r < 97)
                        repeat ($urandom_range(4, 12)) @(posedge clk);
                    else
                        repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    end

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Report checker
    always @(posedge clk)
    begin
        if (rst_n && report_valid && report_ready)
        begin
            if (pen_events_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("unexpected report: kind %0d x %0d y %0d time %0d",
                             report.event_kind, report.pos_x, report.pos_y,
                             report.event_time);
            end
            else
            begin
                want_rep = pen_events_due.pop_front();
                compare_field("event_kind", want_rep.event_kind, report.event_kind);
                compare_field("pos_x", want_rep.pos_x, report.pos_x);
                compare_field("pos_y", want_rep.pos_y, report.pos_y);
                compare_field("event_time", want_rep.event_time, report.event_time);
            end
        end
    end

    // Watchdog on cycles with no accept on any channel
    always @(posedge clk)
    begin
        if ((tick_valid && tick_ready) || (report_valid && report_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main sequence
    initial
    begin
        int start_count;
        bit paused;
        tick_valid    = 1'b0;
        tick          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        mismatches    = 0;
        items_counted = 0;
        idle_cycles   = 0;
        tnow          = '0;
        trk_fast      = 1'b0;
        trk_off_x     = OFFSET_X_RST;
        trk_off_y     = OFFSET_Y_RST;
        trk_gain_x    = GAIN_X_RST;
        trk_gain_y    = GAIN_Y_RST;
        trk_phase     = PH_NONE;
        trk_cur_x     = '0;
        trk_cur_y     = '0;
        trk_last_t    = '0;
        trk_hist_cnt  = 0;
        trk_hist_wp   = 0;
        trk_rejects   = 0;
        for (int i = 0; i < TPT_HISTORY_DEPTH; i++)
        begin
            trk_hist_x[i] = '0;
            trk_hist_y[i] = '0;
        end

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: offsets cancel at 96/116, so the pen lands on the mirror corner
        add_tick(0, 4095, 4095, 0, CHK_QUIET, NO_REPORT);
        add_tick(1, 96, 116, 10, CHK_GIVEN, '{EV_DOWN, 16'sd240, 16'sd320, 32'd10});
        add_tick(1, 96, 116, 20, CHK_QUIET, NO_REPORT);
        add_tick(0, 0, 0, 30, CHK_GIVEN, '{EV_UP, 16'sd240, 16'sd320, 32'd20});
        add_tick(0, 4095, 0, 40, CHK_QUIET, NO_REPORT);
        add_tick(1, 4095, 4095, 50, CHK_MODEL, NO_REPORT);
        // Three rejects in a row empty the history
        add_tick(1, 0, 0, 60, CHK_QUIET, NO_REPORT);
        add_tick(1, 0, 4095, 70, CHK_QUIET, NO_REPORT);
        add_tick(1, 4095, 0, 80, CHK_QUIET, NO_REPORT);
        add_tick(1, 0, 0, 90, CHK_MODEL, NO_REPORT);
        // Threshold edge: one below passes, equal fails
        add_tick(1, 319, 0, 100, CHK_MODEL, NO_REPORT);
        add_tick(1, 639, 320, 110, CHK_QUIET, NO_REPORT);
        add_tick(1, 638, 319, 120, CHK_MODEL, NO_REPORT);
        // Fill the history and wrap its write pointer
        add_tick(1, 700, 400, 130, CHK_MODEL, NO_REPORT);
        add_tick(1, 760, 480, 140, CHK_MODEL, NO_REPORT);
        add_tick(1, 820, 560, 150, CHK_MODEL, NO_REPORT);
        add_tick(1, 880, 640, 32'hFFFF_FFFF, CHK_MODEL, NO_REPORT);
        add_tick(0, 0, 0, 0, CHK_MODEL, NO_REPORT);
        // Fast tracking: threshold 200
        add_reg(REG_FAST_MODE, 16'h0001);
        add_tick(1, 96, 116, 200, CHK_GIVEN, '{EV_DOWN, 16'sd240, 16'sd320, 32'd200});
        add_tick(1, 295, 116, 210, CHK_MODEL, NO_REPORT);
        add_tick(1, 495, 116, 220, CHK_QUIET, NO_REPORT);
        add_tick(0, 4095, 4095, 230, CHK_MODEL, NO_REPORT);
        // Index past the list is ignored; only bit 0 of the mode write counts
        add_reg(REG_GAIN_Y + 3'd1, 16'hFFFF);
        add_reg(REG_FAST_MODE, 16'hFFFE);
        add_tick(1, 96, 116, 240, CHK_GIVEN, '{EV_DOWN, 16'sd240, 16'sd320, 32'd240});
        add_tick(1, 415, 116, 250, CHK_MODEL, NO_REPORT);
        add_tick(0, 0, 4095, 260, CHK_MODEL, NO_REPORT);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                drain();
                write_reg(script[i].index, script[i].data);
            end
            else
                send_tick(script[i].item, gap_len(1'b0), script[i].chk, script[i].given);
        end

        // Random gestures, one calibration per phase
        tnow = 32'd1000;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            configure_phase(ph);
            if (ph == 4)
                hold_req = 1'b1;
            start_count = items_counted;
            paused = 1'b0;
            while (items_counted - start_count < ITEMS_PER_PHASE)
            begin
                if (ph == 6 && !paused && items_counted - start_count >= ITEMS_PER_PHASE / 2)
                begin
                    paused = 1'b1;
                    drain();
                end
                run_gesture(ph == 4);
            end
        end

        drain();
        if (mismatches == 0 && pen_events_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
